// ===== src/stbs_pkg.sv =====
// shared types and constants for the sorted table search block
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int DEPTH_DEF       = 128;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int POS_W  = 7;
  localparam int PROBE_W = 4;
  localparam int OUT_W  = 16;

  localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_LD,
    ST_SORT_LDW,
    ST_SORT_CMP,
    ST_SORT_WI,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RES
  } stbs_state_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [PROBE_W-1:0] comparisons;
  } stbs_res_t;

endpackage

// ===== src/stbs_mem.sv =====
// table memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module stbs_mem #(
  parameter int DEPTH       = stbs_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF,
  parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/stbs_ctrl.sv =====
// sequencer for loading, exchange sorting and binary search over the table memory
`timescale 1ns / 1ps

module stbs_ctrl #(
  parameter int DEPTH       = stbs_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF,
  parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata,
  output logic                   res_valid,
  input  logic                   res_ready,
  output stbs_pkg::stbs_res_t    res
);

  import stbs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

  stbs_state_t state_r, state_nxt;

  logic [CW-1:0]          count_r, count_nxt;
  logic                   open_r, open_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [VALUE_WIDTH-1:0] ti_r, ti_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          end_r, end_nxt;
  logic [CW-1:0]          mid_r, mid_nxt;
  logic [PROBE_W-1:0]     probes_r, probes_nxt;
  stbs_res_t              res_r, res_nxt;

  logic [CW-1:0] slot;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;
  logic [MW-1:0] mid_ext;
  logic [CW:0]   i_inc;
  logic [CW:0]   j_inc;

  assign slot    = open_r ? count_r : '0;
  assign mid_sum = {1'b0, lo_r} + {1'b0, end_r} - 1'b1;
  assign mid_w   = mid_sum[CW:1];
  assign mid_ext = MW'(mid_r);
  assign i_inc   = {1'b0, i_r} + 1'b1;
  assign j_inc   = {1'b0, j_r} + 1'b1;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RES);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      open_r  <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    ti_r     <= ti_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    end_r    <= end_nxt;
    mid_r    <= mid_nxt;
    probes_r <= probes_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    open_nxt   = open_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ti_nxt     = ti_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    end_nxt    = end_r;
    mid_nxt    = mid_r;
    probes_nxt = probes_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = slot[AW-1:0];
    mem_wdata  = in_value;
    mem_raddr  = i_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            count_nxt = slot;
            if ({1'b0, slot} < DEPTH_C) begin
              mem_we    = 1'b1;
              count_nxt = slot + 1'b1;
            end
            if (in_last) begin
              open_nxt  = 1'b0;
              i_nxt     = '0;
              state_nxt = ST_SORT_LD;
            end else begin
              open_nxt = 1'b1;
            end
          end else begin
            key_nxt    = in_value;
            lo_nxt     = '0;
            end_nxt    = count_r;
            probes_nxt = '0;
            state_nxt  = ST_SRCH_RD;
          end
        end
      end

      // fetch the entry at the outer index
      ST_SORT_LD: begin
        mem_raddr = i_r[AW-1:0];
        if (i_inc >= {1'b0, count_r}) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SORT_LDW;
        end
      end

      ST_SORT_LDW: begin
        ti_nxt    = mem_rdata;
        j_nxt     = i_inc[CW-1:0];
        mem_raddr = i_inc[AW-1:0];
        state_nxt = ST_SORT_CMP;
      end

      // compare held entry with entry j, swap through the held register
      ST_SORT_CMP: begin
        if ($signed(ti_r) > $signed(mem_rdata)) begin
          mem_we    = 1'b1;
          mem_waddr = j_r[AW-1:0];
          mem_wdata = ti_r;
          ti_nxt    = mem_rdata;
        end
        if (j_inc < {1'b0, count_r}) begin
          j_nxt     = j_inc[CW-1:0];
          mem_raddr = j_inc[AW-1:0];
        end else begin
          state_nxt = ST_SORT_WI;
        end
      end

      ST_SORT_WI: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[AW-1:0];
        mem_wdata = ti_r;
        i_nxt     = i_inc[CW-1:0];
        state_nxt = ST_SORT_LD;
      end

      ST_SRCH_RD: begin
        mem_raddr = mid_w[AW-1:0];
        if (lo_r < end_r) begin
          mid_nxt    = mid_w;
          probes_nxt = (probes_r == PROBE_MAX) ? probes_r : probes_r + 1'b1;
          state_nxt  = ST_SRCH_CMP;
        end else begin
          res_nxt.found       = 1'b0;
          res_nxt.position    = '0;
          res_nxt.comparisons = probes_r;
          state_nxt           = ST_RES;
        end
      end

      ST_SRCH_CMP: begin
        if (mem_rdata == key_r) begin
          res_nxt.found       = 1'b1;
          res_nxt.position    = mid_ext[POS_W-1:0];
          res_nxt.comparisons = probes_r;
          state_nxt           = ST_RES;
        end else if ($signed(mem_rdata) < $signed(key_r)) begin
          lo_nxt    = mid_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end else begin
          end_nxt   = mid_r;
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sorted_table_binary_search_top.sv =====
// top level of the sorted table binary search block
`timescale 1ns / 1ps

// sorted table binary search
// in_ channel carries one request per handshake: a load (in_tuser = 0) appends
// in_tdata to the table, a search (in_tuser = 1) looks up in_tdata as a key.
// a load with in_tlast high closes the set and starts an in-place exchange sort.
// the first load after reset or after a closed set starts a new set; loads past
// DEPTH entries are dropped, a dropped load with in_tlast still closes the set.
// out_ channel carries one result request per search and nothing for a load.
// each search probe in the table memory puts out the address, then compares the
// registered read data with the key; the probe loop runs on the single read port,
// and the result is then handed off to the output register.
// the sort makes one compare per cycle on the memory read port, and in_tready
// is low meanwhile.
// the result sits in an output register, so the next request is taken while a
// result waits; a second result waits in the sequencer until the register frees.
// reset clears the entry count and the open-set flag; the table needs no clear.

module sorted_table_binary_search_top #(
  parameter int DEPTH       = stbs_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] in_tdata,  // value
  input  logic                                 in_tuser,  // mode
  input  logic                                 in_tlast,  // load_last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [stbs_pkg::OUT_W-1:0]           out_tdata  // found, position, comparisons
);

  import stbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PB = (AW + 1 > 15) ? 15 : AW + 1;

  // table memory ports
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // result hand-off from the sequencer
  logic      res_valid;
  logic      res_ready;
  stbs_res_t res;

  // output register
  logic      out_valid_r, out_valid_nxt;
  stbs_res_t out_res_r, out_res_nxt;

  stbs_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbs_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .in_last   (in_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // the register frees when empty or when its result leaves this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - 1 - POS_W - PROBE_W)'(0),
                       out_res_r.comparisons, out_res_r.position, out_res_r.found};

  // a search never makes more probes than the table depth allows
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:8] <= PROBE_W'(PB)))
    else $error("probe count above bound");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[7:1] == '0))
    else $error("position set on a miss");

  // a hit needs at least one probe
  a_hit_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[11:8] != '0))
    else $error("hit with zero probes");

  // no new request is taken while the sequencer is handing off a result
  a_ready_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("request taken during result hand-off");

endmodule
